// ----- hdl/jswd_pkg.sv -----
package jswd_pkg;
  localparam int DEPTH_DEF = 128;
  localparam int JOINTS_DEF = 7;
  localparam int JW = 3;
  localparam int PW = 32;
  localparam int TW = 16;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_SETTLED = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_IDLE = 2'd3;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_COVER = 3'd1;
  localparam logic [2:0] REG_MIN = 3'd2;
  localparam logic [2:0] REG_MAX = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic start;     // clear window, elapsed and start run
    logic tick;      // advance elapsed, capture sample if any
    logic push;      // write captured sample
    logic drop_chk;  // compare oldest stamp
    logic scan_init; // load oldest sample as min/max seed
    logic scan_step; // fold one sample
    logic finish;    // form result
  } cmd_t;

  typedef struct packed {
    logic running;
    logic drop_now;  // oldest sample is stale
    logic empty;
    logic scan_last; // current scan index is the last sample
  } sts_t;
endpackage

// ----- hdl/joint_settle_window_detector.sv -----
// Sequence: a tick passes through push, a read wait and a drop check (repeated per stale
// sample dropped), then the scan of the samples left in the window, finish and output;
// a start goes through init and finish, and an idle-state transaction straight to output.
// Throughput: one transaction at a time, the next accepted in the cycle after the result
// is taken; seven joints in parallel.
// Reset (rst, synchronous): idle, empty window, config registers at defaults.
module joint_settle_window_detector #(
  parameter int WINDOW_DEPTH = jswd_pkg::DEPTH_DEF,
  parameter int MAX_JOINTS = jswd_pkg::JOINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] command,
  input  logic [2:0] active_joints,
  input  logic signed [31:0] joint0_position,
  input  logic signed [31:0] joint1_position,
  input  logic signed [31:0] joint2_position,
  input  logic signed [31:0] joint3_position,
  input  logic signed [31:0] joint4_position,
  input  logic signed [31:0] joint5_position,
  input  logic signed [31:0] joint6_position,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [31:0] max_range,
  output logic [15:0] covered_ticks,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import jswd_pkg::*;

  logic [15:0] window_ticks, coverage_ticks, min_settle_ticks, max_settle_ticks;
  logic [31:0] range_threshold;
  cmd_t cmd;
  sts_t sts;
  logic busy, idle_result, in_fire;
  logic [1:0] dp_status;
  logic [31:0] dp_range;
  logic [15:0] dp_cov;
  logic [7*32-1:0] all_pos;
  logic [MAX_JOINTS*32-1:0] pos;

  assign all_pos = {joint6_position, joint5_position, joint4_position,
                    joint3_position, joint2_position, joint1_position, joint0_position};
  assign pos = all_pos[MAX_JOINTS*32-1:0];

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= 16'd100;
      coverage_ticks <= 16'd90;
      min_settle_ticks <= 16'd200;
      max_settle_ticks <= 16'd1500;
      range_threshold <= 32'd25166;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW: window_ticks <= cfg_data[15:0];
        REG_COVER: coverage_ticks <= cfg_data[15:0];
        REG_MIN: min_settle_ticks <= cfg_data[15:0];
        REG_MAX: max_settle_ticks <= cfg_data[15:0];
        REG_THRESH: range_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  jswd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .command(command),
    .out_stall(out_stall), .sts(sts), .cmd(cmd), .busy(busy),
    .out_valid(out_valid), .idle_result(idle_result)
  );

  jswd_datapath #(.DEPTH(WINDOW_DEPTH), .JOINTS(MAX_JOINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .command(command),
    .active_joints(active_joints), .positions(pos),
    .window_ticks(window_ticks), .coverage_ticks(coverage_ticks),
    .min_settle_ticks(min_settle_ticks), .max_settle_ticks(max_settle_ticks),
    .range_threshold(range_threshold),
    .status(dp_status), .max_range(dp_range), .covered_ticks(dp_cov)
  );

  assign status = idle_result ? ST_IDLE : dp_status;
  assign max_range = idle_result ? 32'd0 : dp_range;
  assign covered_ticks = idle_result ? 16'd0 : dp_cov;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("accept while busy");
  a_out_after_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(busy) || $past(in_fire)))
    else $error("result without transaction");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("multiple datapath commands");
endmodule

// ----- hdl/jswd_datapath.sv -----
module jswd_datapath #(
  parameter int DEPTH = jswd_pkg::DEPTH_DEF,
  parameter int JOINTS = jswd_pkg::JOINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  jswd_pkg::cmd_t cmd,
  output jswd_pkg::sts_t sts,
  input  logic [1:0] command,
  input  logic [2:0] active_joints,
  input  logic [JOINTS*32-1:0] positions,
  input  logic [15:0] window_ticks,
  input  logic [15:0] coverage_ticks,
  input  logic [15:0] min_settle_ticks,
  input  logic [15:0] max_settle_ticks,
  input  logic [31:0] range_threshold,
  output logic [1:0] status,
  output logic [31:0] max_range,
  output logic [15:0] covered_ticks
);
  import jswd_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [JOINTS*32-1:0] pos_mem [DEPTH];
  logic [15:0] stamp_mem [DEPTH];
  logic [2:0] cnt_mem [DEPTH];

  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic [15:0] elapsed;
  logic running;

  logic [JOINTS*32-1:0] cap_pos;
  logic [2:0] cap_cnt;
  logic cap_valid;

  logic [AW-1:0] rd_addr;
  logic [JOINTS*32-1:0] rd_pos;
  logic [15:0] rd_stamp;
  logic [2:0] rd_cnt;
  logic [FW-1:0] k;      // index of sample being read
  logic scan_adv;

  logic signed [31:0] lo [JOINTS];
  logic signed [31:0] hi [JOINTS];
  logic [2:0] n_old;
  logic [15:0] old_stamp;
  logic same;
  logic [31:0] best;
  logic [15:0] cov;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    logic [AW:0] d;
    d = a - (AW+1)'(DEPTH);
    return (a >= (AW+1)'(DEPTH)) ? d[AW-1:0] : a[AW-1:0];
  endfunction

  logic [2:0] cnt_sat;
  assign cnt_sat = (active_joints > 3'(JOINTS)) ? 3'(JOINTS) : active_joints;

  logic [AW-1:0] wr_slot;
  logic full;
  assign full = (fill >= FW'(DEPTH));
  assign wr_slot = full ? head : wrap({1'b0, head} + (AW+1)'(fill));

  // read address: head + k, one ahead while scanning to cover the read latency
  assign scan_adv = cmd.scan_init | cmd.scan_step;
  assign rd_addr = wrap({1'b0, head} + (AW+1)'(k) + (AW+1)'(scan_adv));

  always_ff @(posedge clk) begin
    if (cmd.push && cap_valid) begin
      pos_mem[wr_slot] <= cap_pos;
      stamp_mem[wr_slot] <= elapsed;
      cnt_mem[wr_slot] <= cap_cnt;
    end
    rd_pos <= pos_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
  end

  always_comb begin
    sts.running = running;
    sts.empty = (fill == '0);
    sts.drop_now = (fill != '0) && ((elapsed - rd_stamp) > window_ticks);
    sts.scan_last = (k + FW'(1) >= fill);
  end

  logic [31:0] rng [JOINTS];
  always_comb begin
    best = '0;
    for (int j = 0; j < JOINTS; j++) begin
      rng[j] = 32'(hi[j] - lo[j]);
      if (3'(j) < n_old && rng[j] > best) best = rng[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      elapsed <= '0;
      running <= 1'b0;
      cap_valid <= 1'b0;
      k <= '0;
    end else begin
      if (cmd.start) begin
        head <= '0;
        fill <= '0;
        elapsed <= '0;
        running <= 1'b1;
        cap_valid <= 1'b0;
        k <= '0;
      end
      if (cmd.tick) begin
        if (elapsed != 16'hFFFF) elapsed <= elapsed + 16'd1;
        cap_valid <= (command == CMD_SAMPLE) && (cnt_sat != 3'd0);
        cap_cnt <= cnt_sat;
        for (int j = 0; j < JOINTS; j++)
          cap_pos[j*32 +: 32] <= (3'(j) < cnt_sat) ? positions[j*32 +: 32] : 32'd0;
        k <= '0;
      end
      if (cmd.push) begin
        if (cap_valid) begin
          if (full) head <= wrap({1'b0, head} + (AW+1)'(1));
          else fill <= fill + FW'(1);
        end
        cap_valid <= 1'b0;
      end
      if (cmd.drop_chk && sts.drop_now) begin
        head <= wrap({1'b0, head} + (AW+1)'(1));
        fill <= fill - FW'(1);
      end
      if (cmd.scan_init) begin
        n_old <= rd_cnt;
        old_stamp <= rd_stamp;
        cov <= '0;
        same <= 1'b1;
        for (int j = 0; j < JOINTS; j++) begin
          lo[j] <= rd_pos[j*32 +: 32];
          hi[j] <= rd_pos[j*32 +: 32];
        end
        k <= FW'(1);
      end
      if (cmd.scan_step) begin
        if (rd_cnt != n_old) same <= 1'b0;
        cov <= rd_stamp - old_stamp;
        for (int j = 0; j < JOINTS; j++) begin
          if ($signed(rd_pos[j*32 +: 32]) < lo[j]) lo[j] <= rd_pos[j*32 +: 32];
          if ($signed(rd_pos[j*32 +: 32]) > hi[j]) hi[j] <= rd_pos[j*32 +: 32];
        end
        k <= k + FW'(1);
      end
      if (cmd.finish) begin
        k <= '0;
        if (fill == '0) begin
          max_range <= '0;
          covered_ticks <= '0;
        end else begin
          max_range <= best;
          covered_ticks <= cov;
        end
        if (elapsed >= min_settle_ticks && fill >= FW'(2) && cov >= coverage_ticks
            && same && best <= range_threshold) begin
          status <= ST_SETTLED;
          running <= 1'b0;
        end else if (elapsed >= max_settle_ticks) begin
          status <= ST_TIMEOUT;
          running <= 1'b0;
        end else begin
          status <= ST_WAIT;
        end
      end
    end
  end
endmodule

// ----- hdl/jswd_ctrl.sv -----
module jswd_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic [1:0] command,
  input  logic out_stall,
  input  jswd_pkg::sts_t sts,
  output jswd_pkg::cmd_t cmd,
  output logic busy,
  output logic out_valid,
  output logic idle_result
);
  import jswd_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;
  localparam logic [2:0] S_RD = 3'd7;

  logic [2:0] state, state_next;
  logic idle_next;

  assign busy = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    idle_next = idle_result;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (command == CMD_START) begin
            cmd.start = 1'b1;
            idle_next = 1'b0;
            state_next = S_INIT;
          end else if (!sts.running) begin
            idle_next = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.tick = 1'b1;
            idle_next = 1'b0;
            state_next = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_next = S_RD;
      end
      // wait for the registered read of the oldest stamp
      S_RD: state_next = S_DROP;
      S_DROP: begin
        cmd.drop_chk = 1'b1;
        state_next = sts.drop_now ? S_RD : S_INIT;
      end
      S_INIT: begin
        if (sts.empty) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_init = 1'b1;
          state_next = sts.scan_last ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        state_next = sts.scan_last ? S_FIN : S_SCAN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idle_result <= 1'b0;
    end else begin
      state <= state_next;
      idle_result <= idle_next;
    end
  end
endmodule

// ----- verif/joint_settle_window_detector_tb.sv -----
module joint_settle_window_detector_tb;
  import jswd_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int NJ = JOINTS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int RAND_ITEMS = 1100;
  localparam logic [1:0] CMD_TICK_ALT = 2'd3;  // unused code, acts as a plain tick

  typedef struct {
    logic [1:0] status;
    logic [31:0] range;
    logic [15:0] covered;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = CMD_TICK;
  logic [2:0] active_joints = 3'd0;
  logic signed [31:0] jp [NJ];
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [31:0] max_range;
  logic [15:0] covered_ticks;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_WINDOW;
  logic [31:0] cfg_data = 32'd0;

  // shadow of the block
  logic signed [31:0] w_pos [DEPTH][NJ];
  logic [15:0] w_stamp [DEPTH];
  logic [2:0] w_cnt [DEPTH];
  int unsigned w_head, w_fill;
  logic [15:0] elapsed;
  bit run_flag;
  int unsigned c_window, c_cover, c_min, c_max;
  logic [31:0] c_thresh;

  verdict_t verdict_q [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_settled = 0;
  int n_timeouts = 0;
  int quiet = 0;
  bit idle_on = 1'b1;

  joint_settle_window_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .active_joints(active_joints),
    .joint0_position(jp[0]), .joint1_position(jp[1]), .joint2_position(jp[2]),
    .joint3_position(jp[3]), .joint4_position(jp[4]), .joint5_position(jp[5]),
    .joint6_position(jp[6]),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .max_range(max_range), .covered_ticks(covered_ticks),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic verdict_t judge_window();
    verdict_t v;
    int unsigned old, n;
    longint lo, hi;
    logic [31:0] r;
    bit same;
    v.status = ST_WAIT;
    v.range = 32'd0;
    v.covered = 16'd0;
    same = 1'b1;
    if (w_fill > 0) begin
      old = w_head;
      n = w_cnt[old];
      v.covered = w_stamp[(w_head + w_fill - 1) % DEPTH] - w_stamp[old];
      for (int k = 0; k < w_fill; k++)
        if (w_cnt[(w_head + k) % DEPTH] != w_cnt[old]) same = 1'b0;
      for (int j = 0; j < n; j++) begin
        lo = w_pos[old][j];
        hi = lo;
        for (int k = 1; k < w_fill; k++) begin
          if (w_pos[(w_head + k) % DEPTH][j] < lo) lo = w_pos[(w_head + k) % DEPTH][j];
          if (w_pos[(w_head + k) % DEPTH][j] > hi) hi = w_pos[(w_head + k) % DEPTH][j];
        end
        r = 32'(hi - lo);
        if (r > v.range) v.range = r;
      end
    end
    if (elapsed >= c_min && w_fill >= 2 && v.covered >= c_cover && same &&
        v.range <= c_thresh) begin
      v.status = ST_SETTLED;
      run_flag = 1'b0;
    end else if (elapsed >= c_max) begin
      v.status = ST_TIMEOUT;
      run_flag = 1'b0;
    end
    return v;
  endfunction

  function automatic verdict_t predict(logic [1:0] cmd, logic [2:0] cnt,
                                       logic signed [31:0] p [NJ]);
    verdict_t v;
    int unsigned s;
    if (cmd == CMD_START) begin
      w_head = 0;
      w_fill = 0;
      elapsed = 16'd0;
      run_flag = 1'b1;
      return judge_window();
    end
    if (!run_flag) begin
      v.status = ST_IDLE;
      v.range = 32'd0;
      v.covered = 16'd0;
      return v;
    end
    if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
    if (cmd == CMD_SAMPLE && cnt != 0) begin
      if (w_fill >= DEPTH) begin
        // store full: overwrite the oldest
        w_head = (w_head + 1) % DEPTH;
        w_fill = DEPTH - 1;
      end
      s = (w_head + w_fill) % DEPTH;
      w_stamp[s] = elapsed;
      w_cnt[s] = cnt;
      for (int j = 0; j < NJ; j++) w_pos[s][j] = (j < cnt) ? p[j] : 32'sd0;
      w_fill++;
    end
    while (w_fill > 0 && (32'(elapsed) - 32'(w_stamp[w_head])) > c_window) begin
      w_head = (w_head + 1) % DEPTH;
      w_fill--;
    end
    return judge_window();
  endfunction

  task automatic send(input logic [1:0] cmd, input logic [2:0] cnt,
                      input logic signed [31:0] p [NJ]);
    int g;
    g = (idle_on && $urandom_range(0, 99) < 18) ? $urandom_range(1, 5) : 0;
    if (g > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    active_joints = cnt;
    for (int j = 0; j < NJ; j++) jp[j] = p[j];
    do @(posedge clk); while (in_stall);
    verdict_q.insert(verdict_q.size(), predict(cmd, cnt, p));
    n_items++;
  endtask

  task automatic send_fill(input logic [1:0] cmd, input logic [2:0] cnt,
                           input logic [31:0] value);
    logic signed [31:0] p [NJ];
    for (int j = 0; j < NJ; j++) p[j] = value;
    send(cmd, cnt, p);
  endtask

  task automatic drain();
    @(negedge clk) in_valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW: c_window = data[15:0];
      REG_COVER:  c_cover = data[15:0];
      REG_MIN:    c_min = data[15:0];
      REG_MAX:    c_max = data[15:0];
      REG_THRESH: c_thresh = data;
      default: ;
    endcase
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic set_all(input int unsigned win, input int unsigned cov, input int unsigned mn,
                         input int unsigned mx, input logic [31:0] th);
    write_reg(REG_WINDOW, win);
    write_reg(REG_COVER, cov);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_THRESH, th);
  endtask

  task automatic test_idle_commands();
    send_fill(CMD_TICK, 3'd0, 32'h0);
    send_fill(CMD_SAMPLE, 3'd3, 32'h1234_5678);
    send_fill(CMD_TICK_ALT, 3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    logic signed [31:0] p [NJ];
    // zero max time: timeout on the start itself
    set_all(100, 90, 200, 0, 25166);
    send_fill(CMD_START, 3'd0, 32'h0);
    send_fill(CMD_TICK, 3'd0, 32'h0);
    // full-scale swing against the widest threshold
    set_all(1, 0, 0, 65535, 32'hFFFF_FFFF);
    send_fill(CMD_START, 3'd7, 32'h0);
    send_fill(CMD_SAMPLE, 3'd7, 32'h7FFF_FFFF);
    send_fill(CMD_SAMPLE, 3'd7, 32'h8000_0000);
    // zero threshold, short window: drops, empty sample, mixed counts
    set_all(1, 65535, 0, 8, 32'h0);
    send_fill(CMD_START, 3'd0, 32'h0);
    for (int j = 0; j < NJ; j++) p[j] = $urandom;
    send(CMD_SAMPLE, 3'd3, p);
    send_fill(CMD_SAMPLE, 3'd0, 32'h5555_5555);
    send_fill(CMD_TICK_ALT, 3'd2, 32'hAAAA_AAAA);
    send(CMD_SAMPLE, 3'd3, p);
    send(CMD_SAMPLE, 3'd5, p);
    send(CMD_SAMPLE, 3'd5, p);
    send_fill(CMD_TICK, 3'd0, 32'h0);
    send_fill(CMD_TICK, 3'd0, 32'h0);
    send(CMD_SAMPLE, 3'd1, p);
    send_fill(CMD_TICK, 3'd0, 32'h0);
    send_fill(CMD_TICK, 3'd0, 32'h0);
  endtask

  task automatic test_store_full();
    logic signed [31:0] p [NJ];
    set_all(65535, 0, 65535, 140, 32'h0);
    send_fill(CMD_START, 3'd0, 32'h0);
    for (int i = 0; i < 141; i++) begin
      for (int j = 0; j < NJ; j++) p[j] = $urandom;
      send(CMD_SAMPLE, 3'd7, p);
    end
  endtask

  task automatic run_sequence();
    logic signed [31:0] base [NJ];
    logic signed [31:0] p [NJ];
    logic [31:0] mask;
    logic [2:0] cnt, c;
    int n, r;
    n = c_max + $urandom_range(2, 6);
    cnt = $urandom_range(1, 7);
    mask = (32'd1 << $urandom_range(0, 31)) - 32'd1;
    for (int j = 0; j < NJ; j++) base[j] = $urandom;
    send_fill(CMD_START, 3'd0, 32'h0);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < NJ; j++) p[j] = base[j] + ($urandom & mask);
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(0, 7)) : cnt;
      if (r < 70)      send(CMD_SAMPLE, c, p);
      else if (r < 85) send(CMD_TICK, c, p);
      else if (r < 92) send(CMD_TICK_ALT, c, p);
      else if (r < 94) send(CMD_START, c, p);
      else             send(CMD_SAMPLE, 3'd0, p);
    end
  endtask

  task automatic test_random_runs();
    int unsigned win, cov, mn, mx;
    logic [31:0] th;
    int phase;
    phase = 0;
    while (n_items < RAND_ITEMS - 100) begin
      idle_on = (phase != 2);
      win = $urandom_range(1, 40);
      cov = $urandom_range(0, win);
      mn = $urandom_range(0, 30);
      mx = $urandom_range(mn, 60);
      case ($urandom_range(0, 3))
        0: th = 32'h0;
        1: th = 32'hFFFF_FFFF;
        2: th = $urandom;
        default: th = 32'd1 << $urandom_range(0, 31);
      endcase
      // occasionally use random register contents, with the max time drawn from 0 to 60
      if ($urandom_range(0, 5) == 0) set_all($urandom, $urandom, $urandom, $urandom_range(0, 60), th);
      else set_all(win, cov, mn, mx, th);
      repeat (3) run_sequence();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) out_stall <= idle_on && ($urandom_range(0, 99) < 18);

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d range %h covered %0d",
                 $time, status, max_range, covered_ticks);
        errors++;
      end else begin
        e = verdict_q[0];
        verdict_q.delete(0);
        if (status == ST_SETTLED) n_settled++;
        if (status == ST_TIMEOUT) n_timeouts++;
        if (status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (max_range !== e.range) begin
          $display("%0t: max_range expected %h got %h", $time, e.range, max_range);
          errors++;
        end
        if (covered_ticks !== e.covered) begin
          $display("%0t: covered_ticks expected %0d got %0d", $time, e.covered, covered_ticks);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("joint_settle_window_detector_tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < NJ; j++) jp[j] = 32'sd0;
    c_window = 100;
    c_cover = 90;
    c_min = 200;
    c_max = 1500;
    c_thresh = 32'd25166;
    w_head = 0;
    w_fill = 0;
    elapsed = 16'd0;
    run_flag = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_idle_commands();
    test_directed();
    test_store_full();
    test_random_runs();
    drain();
    repeat (400) @(posedge clk);
    $display("items sent %0d, results checked %0d, settled %0d, timed out %0d",
             n_items, n_results, n_settled, n_timeouts);
    if (errors == 0 && verdict_q.size() == 0)
      $display("joint_settle_window_detector_tb: done, clean");
    else
      $display("joint_settle_window_detector_tb: done, errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/jswd_pkg.sv
hdl/jswd_datapath.sv
hdl/jswd_ctrl.sv
hdl/joint_settle_window_detector.sv
verif/joint_settle_window_detector_tb.sv
